@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assert failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assert failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/boaht_pkg.sv @@
// constants of the hash table
`timescale 1ns / 1ps
package boaht_pkg;
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [8:0] BUCKETS_RESET = 9'd64;
  localparam logic [4:0] SLOTS_RESET = 5'd4;
endpackage

@@ hw/rtl/boaht_ram.sv @@
// generic single port ram with registered read
`timescale 1ns / 1ps
module boaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ hw/rtl/boaht_front.sv @@
// front end: accepts commands, computes start slot, queues jobs
`timescale 1ns / 1ps
module boaht_front #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BITS = 64,
  parameter int MAX_SLOTS = 16,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_operation,
  input  logic [63:0]         in_lookup_key,
  input  logic [31:0]         in_hash_value,
  input  logic [31:0]         in_entry_value,
  input  logic [8:0]          bucket_count,
  input  logic [4:0]          slots_per_bucket,
  output logic                job_valid,
  input  logic                job_pop,
  output logic [1:0]          job_op,
  output logic [KEY_BITS-1:0] job_key,
  output logic [31:0]         job_val,
  output logic [AW-1:0]       job_start,
  output logic [CW-1:0]       job_cap,
  input  logic                back_idle
);
  typedef enum logic [2:0] {S_IDLE, S_MOD, S_MUL, S_WRAP, S_PUSH} state_t;
  localparam int HW = 32;
  state_t state_r;
  logic [HW-1:0] rem_r;
  logic [HW-1:0] hash_r;
  logic [5:0] bit_r;
  logic [CW-1:0] eb, cap_c;
  logic [6:0] es;
  logic [CW+6:0] prod_r, capw;
  logic [1:0] op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [31:0] val_r;
  logic [HW+CW:0] trial;
  logic qv_r;
  logic [1:0] qop_r;
  logic [KEY_BITS-1:0] qkey_r;
  logic [31:0] qval_r;
  logic [AW-1:0] qst_r;
  logic [CW-1:0] qcap_r;

  always_comb begin
    if (bucket_count == 9'd0) eb = CW'(1);
    else if (32'(bucket_count) > TABLE_DEPTH) eb = CW'(TABLE_DEPTH);
    else eb = CW'(bucket_count);
    if (slots_per_bucket == 5'd0) es = 7'd1;
    else if (32'(slots_per_bucket) > MAX_SLOTS) es = 7'(MAX_SLOTS);
    else es = 7'(slots_per_bucket);
    capw = (CW+7)'(eb) * (CW+7)'(es);
    cap_c = (capw > (CW+7)'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(capw);
    trial = (HW+CW+1)'({rem_r, hash_r[bit_r[4:0]]}) - (HW+CW+1)'(eb);
  end

  assign busy = (state_r != S_IDLE) || qv_r;
  assign job_valid = qv_r;
  assign job_op = qop_r;
  assign job_key = qkey_r;
  assign job_val = qval_r;
  assign job_start = qst_r;
  assign job_cap = qcap_r;

  // restoring remainder, one hash bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      qv_r <= 1'b0;
    end else begin
      if (job_pop) qv_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start && !busy) begin
            op_r <= in_operation;
            key_r <= in_lookup_key[KEY_BITS-1:0];
            val_r <= in_entry_value;
            hash_r <= in_hash_value;
            rem_r <= '0;
            bit_r <= 6'd31;
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          if (trial[HW+CW]) rem_r <= {rem_r[HW-2:0], hash_r[bit_r[4:0]]};
          else rem_r <= HW'(trial);
          if (bit_r == 6'd0) state_r <= S_MUL;
          bit_r <= bit_r - 6'd1;
        end
        S_MUL: begin
          prod_r <= (CW+7)'(rem_r) * (CW+7)'(es);
          state_r <= S_WRAP;
        end
        S_WRAP: begin
          if (prod_r >= (CW+7)'(cap_c)) prod_r <= prod_r - (CW+7)'(cap_c);
          else state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (!qv_r && back_idle) begin
            qv_r <= 1'b1;
            qop_r <= op_r;
            qkey_r <= key_r;
            qval_r <= val_r;
            qst_r <= AW'(prod_r);
            qcap_r <= cap_c;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/boaht_back.sv @@
// back end: probes slots one at a time and reports results
`timescale 1ns / 1ps
`include "assert_macros.svh"
module boaht_back #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BITS = 64,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_flush,
  input  logic                job_valid,
  output logic                job_pop,
  input  logic [1:0]          job_op,
  input  logic [KEY_BITS-1:0] job_key,
  input  logic [31:0]         job_val,
  input  logic [AW-1:0]       job_start,
  input  logic [CW-1:0]       job_cap,
  output logic                idle,
  output logic                out_valid,
  output logic                out_success,
  output logic signed [31:0]  out_read_value,
  output logic [8:0]          out_entry_count,
  output logic                out_is_empty,
  output logic                out_is_full
);
  typedef enum logic [2:0] {S_IDLE, S_ADDR, S_WAIT, S_CHECK, S_FLUSH, S_DONE} state_t;
  state_t state_r;
  logic [CW-1:0] count_r, n_r, cap_r;
  logic [AW-1:0] idx_r;
  logic [1:0] op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [31:0] val_r;
  logic ok_r;
  logic silent_r;
  logic [31:0] rd_r;
  logic we;
  logic vwe, vwd, valid_q;
  logic [KEY_BITS-1:0] key_q;
  logic [31:0] val_q;
  logic [CW-1:0] idx_inc;

  assign we = (state_r == S_CHECK) && (op_r == boaht_pkg::OP_WRITE) && !valid_q;
  assign vwe = we || (state_r == S_FLUSH);
  assign vwd = (state_r != S_FLUSH);
  assign idx_inc = CW'(idx_r) + CW'(1);

  boaht_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_valid (
    .clk(clk), .we(vwe), .addr(idx_r), .wdata(vwd), .rdata(valid_q));
  boaht_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_DEPTH)) u_keys (
    .clk(clk), .we(we), .addr(idx_r), .wdata(key_r), .rdata(key_q));
  boaht_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_vals (
    .clk(clk), .we(we), .addr(idx_r), .wdata(val_r), .rdata(val_q));

  assign idle = (state_r == S_IDLE) && !job_valid;
  assign job_pop = (state_r == S_IDLE) && job_valid;

  // valid bits are cleared by a pass over every slot, after reset too
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FLUSH;
      silent_r <= 1'b1;
      idx_r <= '0;
      count_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cfg_flush) begin
            silent_r <= 1'b1;
            idx_r <= '0;
            count_r <= '0;
            state_r <= S_FLUSH;
          end else if (job_valid) begin
            op_r <= job_op;
            key_r <= job_key;
            val_r <= job_val;
            idx_r <= (job_op == boaht_pkg::OP_FLUSH) ? '0 : job_start;
            cap_r <= job_cap;
            silent_r <= 1'b0;
            n_r <= '0;
            ok_r <= 1'b0;
            rd_r <= '0;
            case (job_op)
              boaht_pkg::OP_WRITE:
                state_r <= (count_r < job_cap) ? S_WAIT : S_DONE;
              boaht_pkg::OP_READ:
                state_r <= (count_r != '0) ? S_WAIT : S_DONE;
              boaht_pkg::OP_FLUSH: state_r <= S_FLUSH;
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_ADDR: state_r <= S_WAIT;
        S_WAIT: state_r <= S_CHECK;
        S_CHECK: begin
          if (!valid_q) begin
            if (op_r == boaht_pkg::OP_WRITE) begin
              count_r <= count_r + CW'(1);
              ok_r <= 1'b1;
            end
            state_r <= S_DONE;
          end else if (op_r == boaht_pkg::OP_READ && key_q == key_r) begin
            ok_r <= 1'b1;
            rd_r <= val_q;
            state_r <= S_DONE;
          end else if (n_r + CW'(1) >= cap_r) begin
            state_r <= S_DONE;
          end else begin
            n_r <= n_r + CW'(1);
            idx_r <= (idx_inc >= cap_r) ? '0 : AW'(idx_inc);
            state_r <= S_ADDR;
          end
        end
        S_FLUSH: begin
          if (idx_r == AW'(TABLE_DEPTH - 1)) begin
            count_r <= '0;
            ok_r <= 1'b1;
            state_r <= silent_r ? S_IDLE : S_DONE;
          end else begin
            idx_r <= idx_r + AW'(1);
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_success <= ok_r;
          out_read_value <= rd_r;
          out_entry_count <= 9'(count_r);
          out_is_empty <= (count_r == '0);
          out_is_full <= (count_r == cap_r);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_count_cap, clk, rst_n, state_r == S_IDLE || state_r == S_FLUSH || count_r <= cap_r)
  `ASSERT_NEXT(a_done_out, clk, rst_n, state_r == S_DONE, out_valid)
  `ASSERT_CLK(a_we_write, clk, rst_n, !we || op_r == boaht_pkg::OP_WRITE)
endmodule

@@ hw/rtl/bucketed_open_address_hash_table.sv @@
// top level of the bucketed open address hash table
// a result is strobed after the start slot wrap steps (up to 15) and the probes
// next command accepted when the result strobe ends
// results are strobed for one cycle; the receiver cannot stall
// sync active low reset restores register defaults, then clears every valid bit
`timescale 1ns / 1ps
module bucketed_open_address_hash_table #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BITS = 64,
  parameter int MAX_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [63:0]        in_lookup_key,
  input  logic [31:0]        in_hash_value,
  input  logic signed [31:0] in_entry_value,
  output logic               out_valid,
  output logic               out_success,
  output logic signed [31:0] out_read_value,
  output logic [8:0]         out_entry_count,
  output logic               out_is_empty,
  output logic               out_is_full,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [8:0]         cfg_data
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  logic [8:0] buckets_r;
  logic [4:0] slots_r;
  logic cfg_flush, fe_busy, jv, jp, bidle;
  logic [1:0] jop;
  logic [KEY_BITS-1:0] jkey;
  logic [31:0] jval;
  logic [AW-1:0] jst;
  logic [CW-1:0] jcap;

  // a register write starts a clearing pass, so only when nothing is in flight
  assign cfg_ready = !busy && !start;
  assign cfg_flush = cfg_valid && cfg_ready;
  assign busy = fe_busy || !bidle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buckets_r <= boaht_pkg::BUCKETS_RESET;
      slots_r <= boaht_pkg::SLOTS_RESET;
    end else if (cfg_flush) begin
      if (cfg_index == 1'b0) buckets_r <= cfg_data;
      else slots_r <= cfg_data[4:0];
    end
  end

  boaht_front #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_BITS(KEY_BITS), .MAX_SLOTS(MAX_SLOTS)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start && !busy), .busy(fe_busy),
    .in_operation(in_operation), .in_lookup_key(in_lookup_key),
    .in_hash_value(in_hash_value), .in_entry_value(in_entry_value),
    .bucket_count(buckets_r), .slots_per_bucket(slots_r),
    .job_valid(jv), .job_pop(jp), .job_op(jop), .job_key(jkey), .job_val(jval),
    .job_start(jst), .job_cap(jcap), .back_idle(bidle));

  boaht_back #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_BITS(KEY_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_flush(cfg_flush),
    .job_valid(jv), .job_pop(jp), .job_op(jop), .job_key(jkey), .job_val(jval),
    .job_start(jst), .job_cap(jcap), .idle(bidle),
    .out_valid(out_valid), .out_success(out_success), .out_read_value(out_read_value),
    .out_entry_count(out_entry_count), .out_is_empty(out_is_empty),
    .out_is_full(out_is_full));
endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for the bucketed open address hash table
`timescale 1ns / 1ps
module testbench;

  localparam int DEPTH = 256;
  localparam int SLOT_MAX = 16;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [0:0] REG_BUCKETS = 1'b0;
  localparam logic [0:0] REG_SLOTS = 1'b1;

  typedef struct packed {
    logic               success;
    logic signed [31:0] read_value;
    logic [8:0]         entry_count;
    logic               is_empty;
    logic               is_full;
  } lookup_result_t;

  class table_scoreboard;
    bit               valid_bits[DEPTH];
    logic [63:0]      keys[DEPTH];
    logic [31:0]      values[DEPTH];
    int unsigned      filled;
    logic [8:0]       buckets;
    logic [4:0]       slots;
    lookup_result_t   pending[$];
    int               mismatches;

    function void reset_state();
      buckets = boaht_pkg::BUCKETS_RESET;
      slots = boaht_pkg::SLOTS_RESET;
      clear_table();
      pending.delete();
      mismatches = 0;
    endfunction

    function void clear_table();
      foreach (valid_bits[i]) valid_bits[i] = 0;
      filled = 0;
    endfunction

    function void write_register(logic [0:0] index, logic [8:0] data);
      if (index == REG_BUCKETS) buckets = data;
      else slots = data[4:0];
      clear_table();
    endfunction

    function void note_command(logic [1:0] op, logic [63:0] key, logic [31:0] hash,
                               logic [31:0] value);
      int unsigned eb, es, cap, home, first, idx;
      lookup_result_t r;
      eb = (buckets == 0) ? 1 : ((buckets > DEPTH) ? DEPTH : buckets);
      es = (slots == 0) ? 1 : ((slots > SLOT_MAX) ? SLOT_MAX : slots);
      cap = (eb * es > DEPTH) ? DEPTH : eb * es;
      home = hash % eb;
      first = (home * es) % cap;
      r = '0;
      case (op)
        boaht_pkg::OP_WRITE: begin
          if (filled < cap) begin
            for (int n = 0; n < cap; n++) begin
              idx = (first + n) % cap;
              if (!valid_bits[idx]) begin
                valid_bits[idx] = 1;
                keys[idx] = key;
                values[idx] = value;
                filled++;
                r.success = 1;
                break;
              end
            end
          end
        end
        boaht_pkg::OP_READ: begin
          if (filled != 0) begin
            for (int n = 0; n < cap; n++) begin
              idx = (first + n) % cap;
              if (!valid_bits[idx]) break;
              if (keys[idx] == key) begin
                r.read_value = values[idx];
                r.success = 1;
                break;
              end
            end
          end
        end
        boaht_pkg::OP_FLUSH: begin
          clear_table();
          r.success = 1;
        end
        default: ;
      endcase
      r.entry_count = filled[8:0];
      r.is_empty = (filled == 0);
      r.is_full = (filled == cap);
      pending.push_back(r);
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_operation = '0;
  logic [63:0] in_lookup_key = '0;
  logic [31:0] in_hash_value = '0;
  logic signed [31:0] in_entry_value = '0;
  logic out_valid, out_success, out_is_empty, out_is_full;
  logic signed [31:0] out_read_value;
  logic [8:0] out_entry_count;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  table_scoreboard sb;
  longint cycles = 0;
  int burst_left = 0;
  logic [63:0] key_pool[16];
  logic [31:0] hash_pool[16];

  always #5 clk = ~clk;

  bucketed_open_address_hash_table i_dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result({out_success, out_read_value, out_entry_count, out_is_empty,
                       out_is_full});
  end

  task automatic send_command(logic [1:0] op, logic [63:0] key, logic [31:0] hash,
                              logic [31:0] value);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
    end
    burst_left--;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    in_operation <= op;
    in_lookup_key <= key;
    in_hash_value <= hash;
    in_entry_value <= value;
    start <= 1;
    do @(posedge clk); while (busy);
    sb.note_command(op, key, hash, value);
  endtask

  task automatic wait_drained();
    start <= 0;
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_config(logic [0:0] index, logic [8:0] data);
    wait_drained();
    cfg_index <= index;
    cfg_data <= data;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.write_register(index, data);
  endtask

  task automatic random_commands(int count);
    int pick, k;
    logic [1:0] op;
    logic [63:0] key;
    logic [31:0] hash;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      op = (pick < 55) ? boaht_pkg::OP_WRITE :
           (pick < 92) ? boaht_pkg::OP_READ :
           (pick < 96) ? boaht_pkg::OP_FLUSH : OP_UNUSED;
      k = $urandom_range(0, 15);
      if ($urandom_range(0, 4) != 0) begin
        key = key_pool[k];
        hash = hash_pool[k];
      end else begin
        key = {$urandom, $urandom};
        hash = $urandom;
      end
      send_command(op, key, hash, $urandom);
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    foreach (key_pool[i]) begin
      key_pool[i] = {$urandom, $urandom};
      hash_pool[i] = $urandom;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    hash_pool[1] = '1;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_command(boaht_pkg::OP_READ, 64'h0, 32'h0, 32'h0);
    send_command(boaht_pkg::OP_WRITE, 64'h0, 32'h0, 32'h7fffffff);
    send_command(boaht_pkg::OP_WRITE, '1, '1, 32'h80000000);
    send_command(boaht_pkg::OP_READ, '1, '1, 32'h0);
    send_command(boaht_pkg::OP_READ, 64'h0, 32'h0, '1);
    send_command(boaht_pkg::OP_WRITE, 64'h0, 32'h0, 32'h12345678);
    send_command(boaht_pkg::OP_READ, 64'h0, 32'h0, 32'h0);
    send_command(boaht_pkg::OP_READ, 64'h5555aaaa5555aaaa, 32'h0, 32'h0);
    send_command(boaht_pkg::OP_WRITE, 64'ha5a5a5a5a5a5a5a5, 32'd64, '1);
    send_command(boaht_pkg::OP_READ, 64'ha5a5a5a5a5a5a5a5, 32'd64, 32'h0);
    send_command(OP_UNUSED, '1, '1, '1);
    send_command(boaht_pkg::OP_FLUSH, 64'h0, 32'h0, 32'h0);
    send_command(boaht_pkg::OP_READ, '1, '1, 32'h0);
    write_config(REG_BUCKETS, 9'd1);
    write_config(REG_SLOTS, 9'd2);
    for (int i = 0; i < 3; i++) send_command(boaht_pkg::OP_WRITE, i, i, i);
    send_command(boaht_pkg::OP_READ, 64'd2, 32'd5, 32'h0);
    send_command(boaht_pkg::OP_READ, 64'd9, 32'd5, 32'h0);
    random_commands(45);

    write_config(REG_BUCKETS, 9'd0);
    write_config(REG_SLOTS, 9'd0);
    random_commands(40);
    write_config(REG_BUCKETS, 9'd256);
    write_config(REG_SLOTS, 9'd16);
    random_commands(50);
    write_config(REG_BUCKETS, 9'd511);
    write_config(REG_SLOTS, 9'h1ff);
    random_commands(40);
    write_config(REG_BUCKETS, 9'd3);
    write_config(REG_SLOTS, 9'd5);
    random_commands(60);
    write_config(REG_BUCKETS, 9'd7);
    write_config(REG_SLOTS, 9'd2);
    random_commands(60);
    write_config(REG_BUCKETS, 9'd100);
    write_config(REG_SLOTS, 9'd3);
    random_commands(60);
    write_config(REG_BUCKETS, 9'd64);
    write_config(REG_SLOTS, 9'd4);
    random_commands(30);

    wait_drained();
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
